FILE: sv/stbs_pkg.sv
// Shared types, constants and microcode program of the sorted-table search core.
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

   localparam int KEY_W     = 16;
   localparam int PAYLOAD_W = 32;
   localparam int SLOT_W    = 6;
   localparam int COUNT_W   = 7;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   localparam int STEP_W = 2;
   localparam logic [STEP_W-1:0] STEP_IDLE  = 2'd0;
   localparam logic [STEP_W-1:0] STEP_PROBE = 2'd1;
   localparam logic [STEP_W-1:0] STEP_HIT   = 2'd2;
   localparam logic [STEP_W-1:0] STEP_MISS  = 2'd3;

   localparam int COND_W = 2;
   localparam logic [COND_W-1:0] COND_ALWAYS = 2'd0;
   localparam logic [COND_W-1:0] COND_START  = 2'd1;
   localparam logic [COND_W-1:0] COND_PROBE  = 2'd2;
   localparam logic [COND_W-1:0] COND_EMIT   = 2'd3;

   typedef struct packed {
      logic              accept;
      logic              probe;
      logic              emit;
      logic              hit;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target_a;
      logic [STEP_W-1:0] target_b;
   } ucode_type;

   typedef struct packed {
      logic start;
      logic empty;
      logic key_eq;
      logic done;
      logic out_free;
   } dp_status_type;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type uc;
      uc = '0;
      case (step)
         STEP_IDLE: begin
            uc.accept   = 1'b1;
            uc.cond     = COND_START;
            uc.target_a = STEP_PROBE;
            uc.target_b = STEP_MISS;
         end
         STEP_PROBE: begin
            uc.probe    = 1'b1;
            uc.cond     = COND_PROBE;
            uc.target_a = STEP_HIT;
            uc.target_b = STEP_MISS;
         end
         STEP_HIT: begin
            uc.emit     = 1'b1;
            uc.hit      = 1'b1;
            uc.cond     = COND_EMIT;
            uc.target_a = STEP_IDLE;
            uc.target_b = STEP_IDLE;
         end
         STEP_MISS: begin
            uc.emit     = 1'b1;
            uc.cond     = COND_EMIT;
            uc.target_a = STEP_IDLE;
            uc.target_b = STEP_IDLE;
         end
         default: begin
            uc.cond     = COND_ALWAYS;
            uc.target_a = STEP_IDLE;
            uc.target_b = STEP_IDLE;
         end
      endcase
      return uc;
   endfunction

endpackage

`default_nettype wire

FILE: sv/stbs_req_if.sv
// Request channel interface: load and search items.
`timescale 1ns / 1ps
`default_nettype none

interface stbs_req_if;
   import stbs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [SLOT_W-1:0]    entry_index;
   logic [KEY_W-1:0]     key;
   logic [PAYLOAD_W-1:0] payload;

   modport source (output valid, mode, entry_index, key, payload, input ready);
   modport sink (input valid, mode, entry_index, key, payload, output ready);
endinterface

`default_nettype wire

FILE: sv/stbs_rsp_if.sv
// Response channel interface: search results.
`timescale 1ns / 1ps
`default_nettype none

interface stbs_rsp_if;
   import stbs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 found;
   logic [SLOT_W-1:0]    match_index;
   logic [PAYLOAD_W-1:0] match_payload;

   modport source (output valid, found, match_index, match_payload, input ready);
   modport sink (input valid, found, match_index, match_payload, output ready);
endinterface

`default_nettype wire

FILE: sv/stbs_table.sv
// Key and payload record memory, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module stbs_table #(
   parameter int TABLE_DEPTH = 64,
   parameter int IDX_W       = 6
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [IDX_W-1:0]              wr_addr,
   input  wire logic [stbs_pkg::KEY_W-1:0]     wr_key,
   input  wire logic [stbs_pkg::PAYLOAD_W-1:0] wr_payload,
   input  wire logic                          rd_en,
   input  wire logic [IDX_W-1:0]              rd_addr,
   output logic      [stbs_pkg::KEY_W-1:0]     rd_key,
   output logic      [stbs_pkg::PAYLOAD_W-1:0] rd_payload
);
   import stbs_pkg::*;

   logic [KEY_W-1:0]     key_mem     [TABLE_DEPTH];
   logic [PAYLOAD_W-1:0] payload_mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]     <= wr_key;
         payload_mem[wr_addr] <= wr_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key     <= key_mem[rd_addr];
         rd_payload <= payload_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: sv/stbs_seq.sv
// Microcode sequencer: step counter, control store and branch logic.
`timescale 1ns / 1ps
`default_nettype none

module stbs_seq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire stbs_pkg::dp_status_type status,
   output stbs_pkg::ucode_type          ctrl
);
   import stbs_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ucode_type         uc;

   assign uc   = ucode_rom(step_ff);
   assign ctrl = uc;

   always_comb begin
      step_in = step_ff;
      case (uc.cond)
         COND_ALWAYS: step_in = uc.target_a;
         COND_START: begin
            if (status.start) begin
               step_in = status.empty ? uc.target_b : uc.target_a;
            end
         end
         COND_PROBE: begin
            if (status.key_eq) begin
               step_in = uc.target_a;
            end else if (status.done) begin
               step_in = uc.target_b;
            end
         end
         COND_EMIT: begin
            if (status.out_free) begin
               step_in = uc.target_a;
            end
         end
         default: step_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/stbs_dp.sv
// Search datapath: bounds, probe address, key compare, count and result registers.
`timescale 1ns / 1ps
`default_nettype none

module stbs_dp #(
   parameter int TABLE_DEPTH = 64,
   parameter int IDX_W       = 6,
   parameter int CNT_W       = 7
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire stbs_pkg::ucode_type            ctrl,
   output stbs_pkg::dp_status_type            status,
   input  wire logic                          csr_wr_en,
   input  wire logic [stbs_pkg::COUNT_W-1:0]   csr_wr_data,
   input  wire logic                          req_valid,
   input  wire logic                          req_mode,
   input  wire logic [stbs_pkg::SLOT_W-1:0]    req_entry_index,
   input  wire logic [stbs_pkg::KEY_W-1:0]     req_key,
   output logic                               tbl_wr_en,
   output logic      [IDX_W-1:0]              tbl_wr_addr,
   output logic                               tbl_rd_en,
   output logic      [IDX_W-1:0]              tbl_rd_addr,
   input  wire logic [stbs_pkg::KEY_W-1:0]     tbl_rd_key,
   input  wire logic [stbs_pkg::PAYLOAD_W-1:0] tbl_rd_payload,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic      [stbs_pkg::SLOT_W-1:0]    rsp_match_index,
   output logic      [stbs_pkg::PAYLOAD_W-1:0] rsp_match_payload
);
   import stbs_pkg::*;

   logic [COUNT_W-1:0]   count_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [CNT_W-1:0]     lo_ff;
   logic [CNT_W-1:0]     hi_ff;
   logic [IDX_W-1:0]     mid_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 found_ff;
   logic [SLOT_W-1:0]    index_ff;
   logic [PAYLOAD_W-1:0] payload_ff;

   logic [CNT_W-1:0]     hi_init;
   logic [IDX_W-1:0]     mid_init;
   logic [CNT_W-1:0]     mid_ext;
   logic [CNT_W-1:0]     lo_n;
   logic [CNT_W-1:0]     hi_n;
   logic [CNT_W:0]       sum_n;
   logic [IDX_W-1:0]     mid_n;
   logic                 search_acc;
   logic                 load_acc;
   logic                 key_lt;
   logic                 emit_fire;

   assign search_acc = ctrl.accept && req_valid && (req_mode == MODE_SEARCH);
   assign load_acc   = ctrl.accept && req_valid && (req_mode == MODE_LOAD);

   assign hi_init  = (32'(count_ff) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                        : CNT_W'(count_ff);
   assign mid_init = IDX_W'(hi_init >> 1);

   assign key_lt  = tbl_rd_key < key_ff;
   assign mid_ext = CNT_W'(mid_ff);
   assign lo_n    = key_lt ? (mid_ext + CNT_W'(1)) : lo_ff;
   assign hi_n    = key_lt ? hi_ff : mid_ext;
   assign sum_n   = {1'b0, lo_n} + {1'b0, hi_n};
   assign mid_n   = IDX_W'(sum_n >> 1);

   assign status.start    = search_acc;
   assign status.empty    = (hi_init == '0);
   assign status.key_eq   = (tbl_rd_key == key_ff);
   assign status.done     = !(lo_n < hi_n);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign emit_fire = ctrl.emit && status.out_free;

   assign tbl_wr_en   = load_acc && (32'(req_entry_index) < 32'(TABLE_DEPTH));
   assign tbl_wr_addr = IDX_W'(req_entry_index);
   assign tbl_rd_en   = (search_acc && !status.empty)
                     || (ctrl.probe && !status.key_eq && !status.done);
   assign tbl_rd_addr = ctrl.probe ? mid_n : mid_init;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (search_acc) begin
         key_ff <= req_key;
         lo_ff  <= '0;
         hi_ff  <= hi_init;
         mid_ff <= mid_init;
      end else if (ctrl.probe && !status.key_eq) begin
         lo_ff  <= lo_n;
         hi_ff  <= hi_n;
         mid_ff <= mid_n;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         found_ff   <= ctrl.hit;
         index_ff   <= ctrl.hit ? SLOT_W'(mid_ff) : '0;
         payload_ff <= ctrl.hit ? tbl_rd_payload : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_match_index   = index_ff;
   assign rsp_match_payload = payload_ff;

endmodule

`default_nettype wire

FILE: sv/sorted_table_binary_search_core.sv
// Top level of the sorted-table binary search core.
//
//   channel  direction  contents
//   req      in         mode, entry_index, key, payload (load or search item)
//   rsp      out        found, match_index, match_payload (one per search)
//   csr      in         entry_count write (csr_wr_en, csr_wr_data)
//
// A load item gives no result.
// A search item makes P probes, P at most ceil(log2(entry_count + 1));
// each probe is one read of the single table read port plus a compare.
// The result register frees the request side while a result waits; a new
// search finishes only once the previous result is taken.
// Reset clears the step counter, entry_count and the result valid; the table is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   stbs_req_if.sink                         req,
   stbs_rsp_if.source                       rsp,
   input  wire logic                        csr_wr_en,
   input  wire logic [stbs_pkg::COUNT_W-1:0] csr_wr_data
);
   import stbs_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   ucode_type            ctrl;
   dp_status_type        status;
   logic                 tbl_wr_en;
   logic [IDX_W-1:0]     tbl_wr_addr;
   logic                 tbl_rd_en;
   logic [IDX_W-1:0]     tbl_rd_addr;
   logic [KEY_W-1:0]     tbl_rd_key;
   logic [PAYLOAD_W-1:0] tbl_rd_payload;

   assign req.ready = ctrl.accept;

   stbs_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   stbs_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req.valid),
      .req_mode          (req.mode),
      .req_entry_index   (req.entry_index),
      .req_key           (req.key),
      .tbl_wr_en         (tbl_wr_en),
      .tbl_wr_addr       (tbl_wr_addr),
      .tbl_rd_en         (tbl_rd_en),
      .tbl_rd_addr       (tbl_rd_addr),
      .tbl_rd_key        (tbl_rd_key),
      .tbl_rd_payload    (tbl_rd_payload),
      .rsp_ready         (rsp.ready),
      .rsp_valid         (rsp.valid),
      .rsp_found         (rsp.found),
      .rsp_match_index   (rsp.match_index),
      .rsp_match_payload (rsp.match_payload)
   );

   stbs_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock      (clock),
      .wr_en      (tbl_wr_en),
      .wr_addr    (tbl_wr_addr),
      .wr_key     (req.key),
      .wr_payload (req.payload),
      .rd_en      (tbl_rd_en),
      .rd_addr    (tbl_rd_addr),
      .rd_key     (tbl_rd_key),
      .rd_payload (tbl_rd_payload)
   );

endmodule

`default_nettype wire
